// ----- rtl/hdep_pkg.sv -----
// Shared types, character codes and calendar tables for the HTTP date parser.
package hdep_pkg;

  localparam int QueueDepthDefault = 2;

  // Parser phases, one-hot.
  typedef enum logic [26:0] {
    PH_WDAY  = 27'd1 << 0,
    PH_SKIP  = 27'd1 << 1,
    PH_D1    = 27'd1 << 2,
    PH_D2    = 27'd1 << 3,
    PH_DSEP  = 27'd1 << 4,
    PH_MON1  = 27'd1 << 5,
    PH_MON2  = 27'd1 << 6,
    PH_MON3  = 27'd1 << 7,
    PH_MSEP  = 27'd1 << 8,
    PH_IOPT  = 27'd1 << 9,
    PH_IDAY1 = 27'd1 << 10,
    PH_IDAY2 = 27'd1 << 11,
    PH_Y1    = 27'd1 << 12,
    PH_Y2    = 27'd1 << 13,
    PH_Y3    = 27'd1 << 14,
    PH_Y4    = 27'd1 << 15,
    PH_TSEP  = 27'd1 << 16,
    PH_H1    = 27'd1 << 17,
    PH_H2    = 27'd1 << 18,
    PH_C1    = 27'd1 << 19,
    PH_MI1   = 27'd1 << 20,
    PH_MI2   = 27'd1 << 21,
    PH_C2    = 27'd1 << 22,
    PH_S1    = 27'd1 << 23,
    PH_S2    = 27'd1 << 24,
    PH_YSEP  = 27'd1 << 25,
    PH_DONE  = 27'd1 << 26
  } phase_t;

  typedef enum logic [1:0] {
    FMT_NONE   = 2'd0,
    FMT_RFC822 = 2'd1,
    FMT_RFC850 = 2'd2,
    FMT_ASC    = 2'd3
  } fmt_t;

  // One parsed date handed from the parser to the converter.
  typedef struct packed {
    logic        bad;
    logic [6:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } rec_t;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpD   = 8'h44;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpJ   = 8'h4A;
  localparam logic [7:0] ChUpM   = 8'h4D;
  localparam logic [7:0] ChUpN   = 8'h4E;
  localparam logic [7:0] ChUpO   = 8'h4F;
  localparam logic [7:0] ChUpS   = 8'h53;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoN   = 8'h6E;
  localparam logic [7:0] ChLoP   = 8'h70;
  localparam logic [7:0] ChLoR   = 8'h72;

  localparam logic [13:0] PivotYear  = 14'd70;
  localparam logic [13:0] Century20  = 14'd2000;
  localparam logic [13:0] Century19  = 14'd1900;

  // floor(y / 100) = (y * Recip100) >> RecipShift for every 14-bit y.
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int          RecipShift = 19;

  // Years are offset by one 400-year cycle so the leap-day sums stay positive.
  localparam logic [13:0] YearShift  = 14'd400;
  localparam logic [8:0]  DaysPerYear = 9'd365;
  // 400-year offset (146097 days) plus the epoch day number, net of the
  // March-based month table offset.
  localparam logic signed [23:0] DayBias   = 24'sd865596;
  localparam logic signed [17:0] SecPerDay = 18'sd86400;
  localparam logic [11:0] SecPerHour = 12'd3600;
  localparam logic [5:0]  SecPerMin  = 6'd60;

  localparam logic [6:0] MaxHour = 7'd23;
  localparam logic [6:0] MaxMin  = 7'd59;
  localparam logic [6:0] LeapDay = 7'd29;
  localparam logic [3:0] MonFeb  = 4'd1;

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd1:                      r = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  // floor(367 * mo / 12) for the March-based month index 1..12.
  function automatic logic [8:0] cum_days(input logic [3:0] mo);
    logic [8:0] r;
    unique case (mo)
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/hdep_front.sv -----
// Character parser: walks the date header one character per cycle while the queue is not full.
module hdep_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  output logic              push,
  output hdep_pkg::rec_t    push_data,
  input  logic              full
);

  hdep_pkg::phase_t phase, phase_next, eff;
  hdep_pkg::fmt_t   fmt, fmt_next;
  logic [6:0]  day_value, day_value_next;
  logic [3:0]  month_value, month_value_next;
  logic [15:0] month_letters, month_letters_next;
  logic [13:0] year_value, year_value_next;
  logic [6:0]  hour_value, hour_value_next;
  logic [6:0]  minute_value, minute_value_next;
  logic [6:0]  second_value, second_value_next;
  logic        failed_flag, failed_flag_next;

  logic        accept;
  logic        dig;
  logic [3:0]  dval;
  logic [13:0] year_x10;
  logic [7:0]  c;

  assign c        = char_code;
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign dig      = (c >= hdep_pkg::ChZero) && (c <= hdep_pkg::ChNine);
  assign dval     = c[3:0];
  assign year_x10 = year_value * 14'd10 + {10'd0, dval};

  always_comb begin
    phase_next         = phase;
    fmt_next           = fmt;
    day_value_next     = day_value;
    month_value_next   = month_value;
    month_letters_next = month_letters;
    year_value_next    = year_value;
    hour_value_next    = hour_value;
    minute_value_next  = minute_value;
    second_value_next  = second_value;
    failed_flag_next   = failed_flag;

    // Leaving the space-skip phases handles the character in the phase that follows.
    eff = phase;
    if (phase == hdep_pkg::PH_SKIP && c != hdep_pkg::ChSpace) begin
      eff = (fmt == hdep_pkg::FMT_ASC) ? hdep_pkg::PH_MON1 : hdep_pkg::PH_D1;
    end
    if (phase == hdep_pkg::PH_IOPT && c != hdep_pkg::ChSpace) begin
      eff = hdep_pkg::PH_IDAY1;
    end
    if (eff != phase) begin
      phase_next = eff;
    end

    if (!failed_flag) begin
      unique case (eff)
        hdep_pkg::PH_WDAY: begin
          if (c == hdep_pkg::ChComma) begin
            phase_next = hdep_pkg::PH_SKIP;
          end else if (c == hdep_pkg::ChSpace) begin
            fmt_next   = hdep_pkg::FMT_ASC;
            phase_next = hdep_pkg::PH_SKIP;
          end
        end
        hdep_pkg::PH_SKIP: ;
        hdep_pkg::PH_IOPT: phase_next = hdep_pkg::PH_IDAY1;
        hdep_pkg::PH_D1, hdep_pkg::PH_IDAY1: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            day_value_next = {3'd0, dval};
            phase_next = (eff == hdep_pkg::PH_D1) ? hdep_pkg::PH_D2 : hdep_pkg::PH_IDAY2;
          end
        end
        hdep_pkg::PH_D2: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            day_value_next = day_value * 7'd10 + {3'd0, dval};
            phase_next     = hdep_pkg::PH_DSEP;
          end
        end
        hdep_pkg::PH_IDAY2: begin
          if (c == hdep_pkg::ChSpace) phase_next = hdep_pkg::PH_H1;
          else if (!dig) failed_flag_next = 1'b1;
          else begin
            day_value_next = day_value * 7'd10 + {3'd0, dval};
            phase_next     = hdep_pkg::PH_TSEP;
          end
        end
        hdep_pkg::PH_DSEP: begin
          if (c == hdep_pkg::ChSpace) begin
            fmt_next   = hdep_pkg::FMT_RFC822;
            phase_next = hdep_pkg::PH_MON1;
          end else if (c == hdep_pkg::ChDash) begin
            fmt_next   = hdep_pkg::FMT_RFC850;
            phase_next = hdep_pkg::PH_MON1;
          end else begin
            failed_flag_next = 1'b1;
          end
        end
        hdep_pkg::PH_MON1: begin
          if (c == hdep_pkg::ChUpJ || c == hdep_pkg::ChUpF || c == hdep_pkg::ChUpM ||
              c == hdep_pkg::ChUpA || c == hdep_pkg::ChUpS || c == hdep_pkg::ChUpO ||
              c == hdep_pkg::ChUpN || c == hdep_pkg::ChUpD) begin
            month_letters_next = {c, 8'd0};
            phase_next         = hdep_pkg::PH_MON2;
          end else begin
            failed_flag_next = 1'b1;
          end
        end
        hdep_pkg::PH_MON2: begin
          month_letters_next = {month_letters[15:8], c};
          phase_next         = hdep_pkg::PH_MON3;
        end
        hdep_pkg::PH_MON3: begin
          unique case (month_letters[15:8])
            hdep_pkg::ChUpJ: month_value_next = (month_letters[7:0] == hdep_pkg::ChLoA) ? 4'd0 :
                                                (c == hdep_pkg::ChLoN) ? 4'd5 : 4'd6;
            hdep_pkg::ChUpF: month_value_next = 4'd1;
            hdep_pkg::ChUpM: month_value_next = (c == hdep_pkg::ChLoR) ? 4'd2 : 4'd4;
            hdep_pkg::ChUpA: month_value_next = (month_letters[7:0] == hdep_pkg::ChLoP) ?
                                                4'd3 : 4'd7;
            hdep_pkg::ChUpS: month_value_next = 4'd8;
            hdep_pkg::ChUpO: month_value_next = 4'd9;
            hdep_pkg::ChUpN: month_value_next = 4'd10;
            default:         month_value_next = 4'd11;
          endcase
          phase_next = hdep_pkg::PH_MSEP;
        end
        hdep_pkg::PH_MSEP: begin
          // The asctime form does not check the character after the month.
          if ((fmt == hdep_pkg::FMT_RFC822 && c != hdep_pkg::ChSpace) ||
              (fmt == hdep_pkg::FMT_RFC850 && c != hdep_pkg::ChDash)) begin
            failed_flag_next = 1'b1;
          end else begin
            phase_next = (fmt == hdep_pkg::FMT_ASC) ? hdep_pkg::PH_IOPT : hdep_pkg::PH_Y1;
          end
        end
        hdep_pkg::PH_Y1: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            year_value_next = {10'd0, dval};
            phase_next      = hdep_pkg::PH_Y2;
          end
        end
        hdep_pkg::PH_Y2: begin
          if (!dig) failed_flag_next = 1'b1;
          else if (fmt == hdep_pkg::FMT_RFC850) begin
            // Two-digit year pivots at 70.
            year_value_next = year_x10 + ((year_x10 < hdep_pkg::PivotYear) ?
                                          hdep_pkg::Century20 : hdep_pkg::Century19);
            phase_next = hdep_pkg::PH_TSEP;
          end else begin
            year_value_next = year_x10;
            phase_next      = hdep_pkg::PH_Y3;
          end
        end
        hdep_pkg::PH_Y3: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            year_value_next = year_x10;
            phase_next      = hdep_pkg::PH_Y4;
          end
        end
        hdep_pkg::PH_Y4: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            year_value_next = year_x10;
            phase_next = (fmt == hdep_pkg::FMT_ASC) ? hdep_pkg::PH_DONE : hdep_pkg::PH_TSEP;
          end
        end
        hdep_pkg::PH_TSEP: begin
          if (c != hdep_pkg::ChSpace) failed_flag_next = 1'b1;
          else phase_next = hdep_pkg::PH_H1;
        end
        hdep_pkg::PH_YSEP: begin
          if (c != hdep_pkg::ChSpace) failed_flag_next = 1'b1;
          else phase_next = hdep_pkg::PH_Y1;
        end
        hdep_pkg::PH_C1: begin
          if (c != hdep_pkg::ChColon) failed_flag_next = 1'b1;
          else phase_next = hdep_pkg::PH_MI1;
        end
        hdep_pkg::PH_C2: begin
          if (c != hdep_pkg::ChColon) failed_flag_next = 1'b1;
          else phase_next = hdep_pkg::PH_S1;
        end
        hdep_pkg::PH_H1: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            hour_value_next = {3'd0, dval};
            phase_next      = hdep_pkg::PH_H2;
          end
        end
        hdep_pkg::PH_H2: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            hour_value_next = hour_value * 7'd10 + {3'd0, dval};
            phase_next      = hdep_pkg::PH_C1;
          end
        end
        hdep_pkg::PH_MI1: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            minute_value_next = {3'd0, dval};
            phase_next        = hdep_pkg::PH_MI2;
          end
        end
        hdep_pkg::PH_MI2: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            minute_value_next = minute_value * 7'd10 + {3'd0, dval};
            phase_next        = hdep_pkg::PH_C2;
          end
        end
        hdep_pkg::PH_S1: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            second_value_next = {3'd0, dval};
            phase_next        = hdep_pkg::PH_S2;
          end
        end
        hdep_pkg::PH_S2: begin
          if (!dig) failed_flag_next = 1'b1;
          else begin
            second_value_next = second_value * 7'd10 + {3'd0, dval};
            phase_next = (fmt == hdep_pkg::FMT_ASC) ? hdep_pkg::PH_YSEP : hdep_pkg::PH_DONE;
          end
        end
        hdep_pkg::PH_DONE: ;
        default: failed_flag_next = 1'b1;
      endcase
    end
  end

  assign push                = accept && last_char;
  assign push_data.bad       = failed_flag_next || (phase_next != hdep_pkg::PH_DONE);
  assign push_data.day       = day_value_next;
  assign push_data.month     = month_value_next;
  assign push_data.year      = year_value_next;
  assign push_data.hour      = hour_value_next;
  assign push_data.minute    = minute_value_next;
  assign push_data.second    = second_value_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase         <= hdep_pkg::PH_WDAY;
      fmt           <= hdep_pkg::FMT_NONE;
      day_value     <= '0;
      month_value   <= '0;
      month_letters <= '0;
      year_value    <= '0;
      hour_value    <= '0;
      minute_value  <= '0;
      second_value  <= '0;
      failed_flag   <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      fmt           <= fmt_next;
      day_value     <= day_value_next;
      month_value   <= month_value_next;
      month_letters <= month_letters_next;
      year_value    <= year_value_next;
      hour_value    <= hour_value_next;
      minute_value  <= minute_value_next;
      second_value  <= second_value_next;
      failed_flag   <= failed_flag_next;
    end
  end

endmodule

// ----- rtl/hdep_queue.sv -----
// Small first-in first-out queue of parsed dates between parser and converter.
module hdep_queue #(
  parameter int Depth = hdep_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hdep_pkg::rec_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output hdep_pkg::rec_t pop_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  hdep_pkg::rec_t entries [Depth];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;

  assign full     = (count == (AW+1)'(Depth));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/hdep_back.sv -----
// Date checker and converter: turns a parsed date into seconds since 1970.
module hdep_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  output logic           pop,
  input  hdep_pkg::rec_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           valid_res,
  output logic [38:0]    epoch_seconds
);

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_DAYS = 4'b0010,
    BK_SEC  = 4'b0100,
    BK_OUT  = 4'b1000
  } bk_state_t;

  bk_state_t state;

  // First step: range checks and the year products.
  logic        low_mon;
  logic [13:0] yp;
  logic [3:0]  mo;
  logic [26:0] prod_y, prod_p;
  logic [22:0] yday_c;
  logic [18:0] tod_c;
  logic        feb29_c, bad_c;

  assign low_mon = (pop_data.month <= hdep_pkg::MonFeb);
  assign yp      = pop_data.year + (low_mon ? (hdep_pkg::YearShift - 14'd1) :
                                              hdep_pkg::YearShift);
  assign mo      = low_mon ? pop_data.month + 4'd11 : pop_data.month - 4'd1;
  assign prod_y  = pop_data.year * hdep_pkg::Recip100;
  assign prod_p  = yp * hdep_pkg::Recip100;
  assign yday_c  = yp * hdep_pkg::DaysPerYear;
  assign tod_c   = pop_data.hour * hdep_pkg::SecPerHour + 19'(pop_data.minute * 13'(hdep_pkg::SecPerMin))
                 + {12'd0, pop_data.second};
  assign feb29_c = (pop_data.day == hdep_pkg::LeapDay) && (pop_data.month == hdep_pkg::MonFeb);
  assign bad_c   = pop_data.bad || (pop_data.hour > hdep_pkg::MaxHour) ||
                   (pop_data.minute > hdep_pkg::MaxMin) || (pop_data.second > hdep_pkg::MaxMin) ||
                   (!feb29_c && (pop_data.day > {2'd0, hdep_pkg::month_days(pop_data.month)}));

  logic        s_bad, s_feb29;
  logic [13:0] s_year, s_yp;
  logic [7:0]  s_qy, s_qp;
  logic [22:0] s_yday;
  logic [18:0] s_tod;
  logic [3:0]  s_mo;
  logic [6:0]  s_day;

  // Second step: leap-year check and the day count.
  logic [13:0] rem_y;
  logic        leap_bad;
  logic [13:0] leap_sum;
  logic [23:0] day_sum;
  logic signed [23:0] days_c;

  assign rem_y    = s_year - s_qy * 14'd100;
  assign leap_bad = s_feb29 && ((s_year[1:0] != 2'd0) ||
                                ((rem_y == 14'd0) && (s_qy[1:0] != 2'd0)));
  assign leap_sum = (s_yp >> 2) - {6'd0, s_qp} + {8'd0, s_qp[7:2]};
  assign day_sum  = {1'b0, s_yday} + {10'd0, leap_sum} + {15'd0, hdep_pkg::cum_days(s_mo)}
                  + {17'd0, s_day};
  assign days_c   = $signed(day_sum) - hdep_pkg::DayBias;

  logic               d_bad;
  logic signed [23:0] d_days;

  // Third step: scale to seconds.
  logic signed [41:0] sec_prod, sec_total;

  assign sec_prod  = d_days * hdep_pkg::SecPerDay;
  assign sec_total = sec_prod + $signed({23'd0, s_tod});

  assign pop       = (state == BK_IDLE) && !empty;
  assign out_valid = (state == BK_OUT);

  always_ff @(posedge clk) begin
    if (pop) begin
      s_bad   <= bad_c;
      s_feb29 <= feb29_c;
      s_year  <= pop_data.year;
      s_yp    <= yp;
      s_qy    <= prod_y[26:hdep_pkg::RecipShift];
      s_qp    <= prod_p[26:hdep_pkg::RecipShift];
      s_yday  <= yday_c;
      s_tod   <= tod_c;
      s_mo    <= mo;
      s_day   <= pop_data.day;
    end
    if (state == BK_DAYS) begin
      d_bad  <= s_bad || leap_bad;
      d_days <= days_c;
    end
    if (state == BK_SEC) begin
      valid_res     <= !d_bad;
      epoch_seconds <= d_bad ? '1 : sec_total[38:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      unique case (state)
        BK_IDLE: if (!empty) state <= BK_DAYS;
        BK_DAYS: state <= BK_SEC;
        BK_SEC:  state <= BK_OUT;
        BK_OUT:  if (out_ready) state <= BK_IDLE;
        default: state <= BK_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/http_date_to_epoch_parser.sv -----
// HTTP Date header parser: characters in, validity flag and Unix time out.
//
// The block reads the characters of one HTTP Date header value, one character
// per slave transaction, with tlast on the final character. It accepts the
// RFC 1123 form ("Tue, 10 Nov 2002 23:50:13"), the RFC 850 form
// ("Tuesday, 10-Nov-02 23:50:13", two-digit years below 70 mean 20yy) and
// the asctime form ("Tue Nov 10 23:50:13 2002"); text after the seconds or
// the asctime year is ignored. Each value gives exactly one master
// transaction: tuser[0] is 1 when the date parsed and passed the range,
// month-length and leap-year checks, and tdata carries the seconds since
// 1970-01-01 00:00:00 UTC as a 39-bit two's complement number (all ones when
// the date is invalid). The parser takes one character per cycle; it stalls
// only when the queue of finished values is full. The converter behind the
// queue works through its steps in order (range checks and year products, the day
// count, the multiply by seconds per day, then the output register) and
// holds its result until the master side takes it; only then does it take the
// next date from the queue. QUEUE_DEPTH sets how many parsed dates may wait for
// the converter. After reset the block is ready at once.
module http_date_to_epoch_parser #(
  parameter int QUEUE_DEPTH = hdep_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
  output logic [0:0]  m_axis_tuser    // [0] valid_res
);

  hdep_pkg::rec_t push_data, pop_data;
  logic           push, full, pop, empty;
  logic           valid_res;
  logic [38:0]    epoch_seconds;

  // The parser runs ahead on the character stream and hands one record per
  // header value to the queue.
  hdep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .char_code (s_axis_tdata),
    .last_char (s_axis_tlast),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  hdep_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  // The converter works on one record at a time and owns the output register.
  hdep_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .pop           (pop),
    .pop_data      (pop_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .valid_res     (valid_res),
    .epoch_seconds (epoch_seconds)
  );

  assign m_axis_tdata = {1'b0, epoch_seconds};
  assign m_axis_tuser = valid_res;

endmodule

// ----- tb/sv/http_date_epoch_checker.sv -----
// Channel checker for the HTTP date parser: predicts each date result and compares it.
module http_date_epoch_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // last_char
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
  input  logic [0:0]  m_axis_tuser,   // [0] valid_res
  output int          fail_count,
  output int          owed_count
);

  typedef struct {
    logic        ok;
    logic [38:0] secs;
  } date_result_t;

  date_result_t owed_q[$];
  int           err_cnt = 0;

  // Parser state as seen from the character stream.
  hdep_pkg::phase_t prs_phase;
  hdep_pkg::fmt_t   prs_fmt;
  logic [6:0]  prs_day;
  logic [3:0]  prs_month;
  logic [15:0] prs_mletters;
  logic [13:0] prs_year;
  logic [6:0]  prs_hour;
  logic [6:0]  prs_min;
  logic [6:0]  prs_sec;
  logic        prs_bad;

  function automatic void clear_parse();
    prs_phase    = hdep_pkg::PH_WDAY;
    prs_fmt      = hdep_pkg::FMT_NONE;
    prs_day      = '0;
    prs_month    = '0;
    prs_mletters = '0;
    prs_year     = '0;
    prs_hour     = '0;
    prs_min      = '0;
    prs_sec      = '0;
    prs_bad      = 1'b0;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic int unsigned days_in_month(input logic [3:0] m);
    case (m)
      4'd1:                    return 28;
      4'd3, 4'd5, 4'd8, 4'd10: return 30;
      default:                 return 31;
    endcase
  endfunction

  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    logic [6:0] dig;
    logic [7:0] lead;
    logic [7:0] follow;
    dig = 7'(c - 8'h30);
    if (prs_bad || prs_phase == hdep_pkg::PH_DONE) return;
    if (prs_phase == hdep_pkg::PH_WDAY) begin
      if (c == ",") begin
        prs_phase = hdep_pkg::PH_SKIP;
      end else if (c == " ") begin
        prs_fmt   = hdep_pkg::FMT_ASC;
        prs_phase = hdep_pkg::PH_SKIP;
      end
      return;
    end
    // The first non-space after the weekday is handled by the next phase.
    if (prs_phase == hdep_pkg::PH_SKIP) begin
      if (c == " ") return;
      if (prs_fmt == hdep_pkg::FMT_ASC) prs_phase = hdep_pkg::PH_MON1;
      else prs_phase = hdep_pkg::PH_D1;
    end
    if (prs_phase == hdep_pkg::PH_IOPT) begin
      prs_phase = hdep_pkg::PH_IDAY1;
      if (c == " ") return;
    end
    if (prs_phase == hdep_pkg::PH_IDAY2 && c == " ") begin
      prs_phase = hdep_pkg::PH_H1;
      return;
    end
    if (prs_phase inside {hdep_pkg::PH_D1, hdep_pkg::PH_D2, hdep_pkg::PH_IDAY1,
                          hdep_pkg::PH_IDAY2, hdep_pkg::PH_Y1, hdep_pkg::PH_Y2,
                          hdep_pkg::PH_Y3, hdep_pkg::PH_Y4, hdep_pkg::PH_H1,
                          hdep_pkg::PH_H2, hdep_pkg::PH_MI1, hdep_pkg::PH_MI2,
                          hdep_pkg::PH_S1, hdep_pkg::PH_S2} && !is_digit(c)) begin
      prs_bad = 1'b1;
      return;
    end
    case (prs_phase)
      hdep_pkg::PH_D1: begin
        prs_day   = dig;
        prs_phase = hdep_pkg::PH_D2;
      end
      hdep_pkg::PH_D2: begin
        prs_day   = 7'(prs_day * 10 + dig);
        prs_phase = hdep_pkg::PH_DSEP;
      end
      hdep_pkg::PH_DSEP: begin
        if (c == " ") prs_fmt = hdep_pkg::FMT_RFC822;
        else if (c == "-") prs_fmt = hdep_pkg::FMT_RFC850;
        else prs_bad = 1'b1;
        if (!prs_bad) prs_phase = hdep_pkg::PH_MON1;
      end
      hdep_pkg::PH_MON1: begin
        if (c inside {"J", "F", "M", "A", "S", "O", "N", "D"}) begin
          prs_mletters = {c, 8'h00};
          prs_phase    = hdep_pkg::PH_MON2;
        end else begin
          prs_bad = 1'b1;
        end
      end
      hdep_pkg::PH_MON2: begin
        prs_mletters[7:0] = c;
        prs_phase         = hdep_pkg::PH_MON3;
      end
      hdep_pkg::PH_MON3: begin
        lead   = prs_mletters[15:8];
        follow = prs_mletters[7:0];
        // Months are numbered from 0 for January.
        case (lead)
          "J":     prs_month = (follow == "a") ? 4'd0 : (c == "n") ? 4'd5 : 4'd6;
          "F":     prs_month = 4'd1;
          "M":     prs_month = (c == "r") ? 4'd2 : 4'd4;
          "A":     prs_month = (follow == "p") ? 4'd3 : 4'd7;
          "S":     prs_month = 4'd8;
          "O":     prs_month = 4'd9;
          "N":     prs_month = 4'd10;
          default: prs_month = 4'd11;
        endcase
        prs_phase = hdep_pkg::PH_MSEP;
      end
      hdep_pkg::PH_MSEP: begin
        if ((prs_fmt == hdep_pkg::FMT_RFC822 && c != " ") ||
            (prs_fmt == hdep_pkg::FMT_RFC850 && c != "-")) begin
          prs_bad = 1'b1;
        end else if (prs_fmt == hdep_pkg::FMT_ASC) begin
          prs_phase = hdep_pkg::PH_IOPT;
        end else begin
          prs_phase = hdep_pkg::PH_Y1;
        end
      end
      hdep_pkg::PH_IDAY1: begin
        prs_day   = dig;
        prs_phase = hdep_pkg::PH_IDAY2;
      end
      hdep_pkg::PH_IDAY2: begin
        prs_day   = 7'(prs_day * 10 + dig);
        prs_phase = hdep_pkg::PH_TSEP;
      end
      hdep_pkg::PH_Y1: begin
        prs_year  = 14'(dig);
        prs_phase = hdep_pkg::PH_Y2;
      end
      hdep_pkg::PH_Y2: begin
        prs_year = 14'(prs_year * 10 + dig);
        if (prs_fmt == hdep_pkg::FMT_RFC850) begin
          prs_year  = 14'(prs_year + ((prs_year < 70) ? 2000 : 1900));
          prs_phase = hdep_pkg::PH_TSEP;
        end else begin
          prs_phase = hdep_pkg::PH_Y3;
        end
      end
      hdep_pkg::PH_Y3: begin
        prs_year  = 14'(prs_year * 10 + dig);
        prs_phase = hdep_pkg::PH_Y4;
      end
      hdep_pkg::PH_Y4: begin
        prs_year = 14'(prs_year * 10 + dig);
        if (prs_fmt == hdep_pkg::FMT_ASC) prs_phase = hdep_pkg::PH_DONE;
        else prs_phase = hdep_pkg::PH_TSEP;
      end
      hdep_pkg::PH_TSEP: begin
        if (c != " ") prs_bad = 1'b1;
        else prs_phase = hdep_pkg::PH_H1;
      end
      hdep_pkg::PH_YSEP: begin
        if (c != " ") prs_bad = 1'b1;
        else prs_phase = hdep_pkg::PH_Y1;
      end
      hdep_pkg::PH_C1: begin
        if (c != ":") prs_bad = 1'b1;
        else prs_phase = hdep_pkg::PH_MI1;
      end
      hdep_pkg::PH_C2: begin
        if (c != ":") prs_bad = 1'b1;
        else prs_phase = hdep_pkg::PH_S1;
      end
      hdep_pkg::PH_H1: begin
        prs_hour  = dig;
        prs_phase = hdep_pkg::PH_H2;
      end
      hdep_pkg::PH_H2: begin
        prs_hour  = 7'(prs_hour * 10 + dig);
        prs_phase = hdep_pkg::PH_C1;
      end
      hdep_pkg::PH_MI1: begin
        prs_min   = dig;
        prs_phase = hdep_pkg::PH_MI2;
      end
      hdep_pkg::PH_MI2: begin
        prs_min   = 7'(prs_min * 10 + dig);
        prs_phase = hdep_pkg::PH_C2;
      end
      hdep_pkg::PH_S1: begin
        prs_sec   = dig;
        prs_phase = hdep_pkg::PH_S2;
      end
      hdep_pkg::PH_S2: begin
        prs_sec = 7'(prs_sec * 10 + dig);
        if (prs_fmt == hdep_pkg::FMT_ASC) prs_phase = hdep_pkg::PH_YSEP;
        else prs_phase = hdep_pkg::PH_DONE;
      end
      default: prs_bad = 1'b1;
    endcase
  endfunction

  // Checks the parsed fields and converts them to seconds since 1970.
  function automatic date_result_t date_to_epoch();
    date_result_t r;
    longint       yr;
    longint       mo;
    longint       days;
    longint       t;
    logic         leap;
    r.ok   = 1'b0;
    r.secs = '1;
    leap   = (prs_year % 4 == 0) && ((prs_year % 100 != 0) || (prs_year % 400 == 0));
    if (prs_bad || prs_phase != hdep_pkg::PH_DONE || prs_month > 11) return r;
    if (prs_hour > 23 || prs_min > 59 || prs_sec > 59) return r;
    if (prs_day == 29 && prs_month == 4'd1) begin
      if (!leap) return r;
    end else if (prs_day > days_in_month(prs_month)) begin
      return r;
    end
    // Count from March so the leap day falls at the end of the year.
    yr = longint'(prs_year);
    mo = longint'(prs_month) - 1;
    if (mo <= 0) begin
      mo = mo + 12;
      yr = yr - 1;
    end
    days = 365 * yr + floor_quot(yr, 4) - floor_quot(yr, 100) + floor_quot(yr, 400)
         + (367 * mo) / 12 - 30 + longint'(prs_day) - 1 - 719527 + 31 + 28;
    t = days * 86400 + longint'(prs_hour) * 3600 + longint'(prs_min) * 60
      + longint'(prs_sec);
    r.ok   = 1'b1;
    r.secs = t[38:0];
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [39:0] want,
                               input logic [39:0] got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch in %s at %0t: expected %h, got %h", what, $time, want, got);
  endtask

  always @(posedge clk) begin
    date_result_t exp_res;
    if (rst) begin
      clear_parse();
      owed_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          note_mismatch("result with none owed", 40'h0, m_axis_tdata);
        end else begin
          exp_res = owed_q.pop_front();
          if (m_axis_tuser[0] !== exp_res.ok)
            note_mismatch("valid flag", {39'h0, exp_res.ok}, {39'h0, m_axis_tuser[0]});
          if (m_axis_tdata !== {1'b0, exp_res.secs})
            note_mismatch("epoch seconds", {1'b0, exp_res.secs}, m_axis_tdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_char(s_axis_tdata);
        if (s_axis_tlast) begin
          owed_q.push_back(date_to_epoch());
          clear_parse();
        end
      end
    end
    fail_count <= err_cnt;
    owed_count <= owed_q.size();
  end

endmodule

// ----- tb/sv/http_date_to_epoch_parser_tb.sv -----
// Top of the HTTP date parser testbench: clock, reset, character stimulus and verdict.
module http_date_to_epoch_parser_tb;

  localparam int unsigned CycleLimit = 200000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] char_code
  logic        s_axis_tlast  = 1'b0;    // last_char
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [39:0] m_axis_tdata;            // [38:0] epoch_seconds, [39] zero
  logic [0:0]  m_axis_tuser;            // [0] valid_res

  int          fail_count;
  int          owed_count;
  int unsigned sender_idle_pct    = 13;
  int unsigned receiver_stall_pct = 74;
  int unsigned cycle_cnt          = 0;

  // Characters of the header value that is sent next.
  logic [7:0]  hdr_q[$];

  // Hand-picked values: each accepted form, the calendar extremes, the leap-day
  // rules, range violations, early ends, bad characters and ignored trailers.
  string directed_dates[$] = '{
    "Sun, 06 Nov 1994 08:49:37 GMT",
    "Sunday, 06-Nov-94 08:49:37 GMT",
    "Sun Nov  6 08:49:37 1994",
    "Thu Jan 01 00:00:00 1970 trailing",
    "Sat, 01 Jan 0000 00:00:00",
    "Tue, 29 Feb 0000 12:34:56",
    "Fri, 31 Dec 9999 23:59:59",
    "Tue, 29 Feb 2000 00:00:00",
    "Thu, 29 Feb 1900 00:00:00",
    "Thu, 29 Feb 2001 00:00:00",
    "Thu, 31 Apr 2020 00:00:00",
    "Thu, 00 Mar 2020 00:00:00",
    "Thu, 10 Mar 2020 24:00:00",
    "Thu, 10 Mar 2020 23:60:00",
    "Thu, 10 Mar 2020 23:59:60",
    "Wednesday,   10-Jun-69 01:02:03",
    "Wednesday, 10-Jul-70 01:02:03",
    "Tue Aug?5 23:50:13 2002",
    "Tue, 10 Nov",
    "Tuesday",
    ",",
    "Tue, 1x Nov 2002 23:50:13",
    "Tue, 10 Xyz 2002 23:50:13",
    "Tue, 10 Nov 2002 23:50:13\377"
  };

  http_date_to_epoch_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // The checker sits beside the block, predicts every result from the slave
  // channel and compares the master channel against it.
  http_date_epoch_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .owed_count    (owed_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver drops tready at random, at the rate of the current phase.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("http_date_to_epoch_parser_tb NOT OK");
      $finish;
    end
  end

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
  endtask

  // Offers one character and returns right after the edge that accepted it.
  // Valid stays high between back-to-back transactions; it drops only for an
  // idle cycle, so it is never lowered and raised within one time step.
  task automatic push_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Sends the queued value with tlast on its final character.
  task automatic send_header();
    for (int i = 0; i < hdr_q.size(); i++) push_char(hdr_q[i], i == hdr_q.size() - 1);
    hdr_q.delete();
  endtask

  // Builds a mostly well-formed date in one of the three forms, with random
  // weekday bytes, fields that now and then leave their range, odd month
  // letters and trailing bytes. Some values are then corrupted or cut short.
  task automatic build_date_text();
    string       names;
    int unsigned style;
    int unsigned mon;
    int unsigned day;
    int unsigned year;
    int unsigned hour;
    int unsigned minute;
    int unsigned sec;
    int unsigned cut;
    logic [7:0]  ch;
    names  = "JanFebMarAprMayJunJulAugSepOctNovDec";
    style  = $urandom_range(2);
    mon    = $urandom_range(11);
    day    = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(31);
    year   = ($urandom_range(3) == 0) ? 100 * $urandom_range(99) : $urandom_range(9999);
    hour   = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(23);
    minute = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
    sec    = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
    // Steer some dates onto the end of February to exercise the leap rules.
    if ($urandom_range(9) == 0) begin
      mon = 1;
      day = $urandom_range(28, 30);
    end

    repeat ($urandom_range(9)) begin
      ch = 8'($urandom_range(255));
      if (ch == "," || ch == " ") ch = "d";
      hdr_q.push_back(ch);
    end
    if (style == 2) add_str(" ");
    else add_str(",");
    repeat ($urandom_range(2)) add_str(" ");

    if (style == 0) add_str($sformatf("%02d ", day));
    if (style == 1) add_str($sformatf("%02d-", day));
    hdr_q.push_back(names[3 * mon]);
    hdr_q.push_back(($urandom_range(5) == 0) ? 8'($urandom_range(255)) : names[3 * mon + 1]);
    hdr_q.push_back(($urandom_range(5) == 0) ? 8'($urandom_range(255)) : names[3 * mon + 2]);

    case (style)
      0: add_str($sformatf(" %04d %02d:%02d:%02d", year, hour, minute, sec));
      1: add_str($sformatf("-%02d %02d:%02d:%02d", year % 100, hour, minute, sec));
      default: begin
        // The asctime separator after the month is not checked by the block.
        hdr_q.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h20);
        if (day < 10 && $urandom_range(1) == 0) begin
          if ($urandom_range(1) == 0) add_str(" ");
          add_str($sformatf("%0d", day));
        end else begin
          add_str($sformatf("%02d", day));
        end
        add_str($sformatf(" %02d:%02d:%02d %04d", hour, minute, sec, year));
      end
    endcase
    repeat ($urandom_range(3)) hdr_q.push_back(8'($urandom_range(255)));

    case ($urandom_range(99)) inside
      [0:11]: hdr_q[$urandom_range(hdr_q.size() - 1)] = 8'($urandom_range(255));
      [12:19]: begin
        cut = $urandom_range(1, hdr_q.size() - 1);
        while (hdr_q.size() > cut) void'(hdr_q.pop_back());
      end
      default: ;
    endcase
  endtask

  initial begin
    int unsigned chars_in_pass;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_dates[i]) begin
      add_str(directed_dates[i]);
      send_header();
    end
    // A NUL byte in the weekday is skipped like any other character.
    hdr_q.push_back(8'h00);
    add_str(", 01 Jan 1970 00:00:01");
    send_header();

    // Three random passes: fast sender with a stalling receiver, the reverse,
    // then full rate on both sides.
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          sender_idle_pct    <= 13;
          receiver_stall_pct <= 74;
        end
        1: begin
          sender_idle_pct    <= 74;
          receiver_stall_pct <= 13;
        end
        default: begin
          sender_idle_pct    <= 0;
          receiver_stall_pct <= 0;
        end
      endcase
      chars_in_pass = 0;
      while (chars_in_pass < 80) begin
        if ($urandom_range(19) == 0) begin
          // Pure noise, which mostly ends up invalid.
          repeat ($urandom_range(1, 40)) hdr_q.push_back(8'($urandom_range(255)));
        end else begin
          build_date_text();
        end
        chars_in_pass += hdr_q.size();
        send_header();
      end
    end
    s_axis_tvalid <= 1'b0;

    // The owed count is a registered copy of the queue size, so wait for it to catch up first.
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("http_date_to_epoch_parser_tb OK");
    end else begin
      $display("http_date_to_epoch_parser_tb NOT OK");
    end
    $finish;
  end

endmodule
